// ===== src/fesk_pkg.sv =====
// Shared types, constants and the row layout table of the plane frame
// element stiffness block. No dependencies.
`default_nettype none

package fesk_pkg;

  // Stream widths: eight 32-bit input fields, and the output row padded to bytes.
  localparam int InW  = 256;
  localparam int OutW = 392;

  // Quotient bits produced by every divider.
  localparam int QuoW = 64;

  // Matrix shape.
  localparam int NumRows = 6;
  localparam int NumCols = 6;
  localparam int NumVals = 7;
  localparam logic [2:0] LastRow = 3'd5;

  // Saturation bounds of a signed Q32.32 entry.
  localparam logic [63:0] MaxS64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinS64 = 64'h8000_0000_0000_0000;

  // Positions of the distinct matrix values.
  localparam int IdxP  = 0;
  localparam int IdxQ  = 1;
  localparam int IdxR  = 2;
  localparam int IdxCs = 3;
  localparam int IdxCc = 4;
  localparam int IdxD  = 5;
  localparam int IdxE  = 6;

  // One input word, first field in the lowest bits.
  typedef struct packed {
    logic signed [31:0] end_y;
    logic signed [31:0] end_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_x;
    logic [31:0]        beam_length;
    logic [31:0]        section_area;
    logic [31:0]        second_moment;
    logic [31:0]        youngs_modulus;
  } fesk_in_t;

  // One finished matrix: the seven values, their saturating negations, and
  // the zero length flag.
  typedef struct packed {
    logic                        zero;
    logic [NumVals-1:0][63:0]    neg;
    logic [NumVals-1:0][63:0]    pos;
  } fesk_mat_t;

  // Which stored value an entry of the matrix shows.
  typedef enum logic [3:0] {
    SEL_P, SEL_Q, SEL_R, SEL_CS, SEL_CC, SEL_D, SEL_E,
    SEL_NP, SEL_NQ, SEL_NR, SEL_NCS, SEL_NCC, SEL_ND, SEL_NE
  } sel_e;

  // Layout of the global matrix, row by row.
  localparam sel_e RowSel [NumRows][NumCols] = '{
    '{SEL_P,   SEL_Q,  SEL_NCS, SEL_NP,  SEL_NQ,  SEL_NCS},
    '{SEL_Q,   SEL_R,  SEL_CC,  SEL_NQ,  SEL_NR,  SEL_CC },
    '{SEL_NCS, SEL_CC, SEL_D,   SEL_CS,  SEL_NCC, SEL_E  },
    '{SEL_NP,  SEL_NQ, SEL_CS,  SEL_P,   SEL_Q,   SEL_CS },
    '{SEL_NQ,  SEL_NR, SEL_NCC, SEL_Q,   SEL_R,   SEL_NCC},
    '{SEL_NCS, SEL_CC, SEL_E,   SEL_CS,  SEL_NCC, SEL_D  }
  };

endpackage

`default_nettype wire

// ===== src/frame_element_stiffness_2d.sv =====
// Top level of the plane frame element stiffness block: input stream, the
// arithmetic pipeline and the row serializer. Depends on fesk_pkg, fesk_core.
//
// Usage:
//   The slave stream takes one beam element per word on s_axis_tdata
//   (E, I, A, L, start x/y, end x/y, 32 bits each, E in the lowest bits).
//   The master stream gives the global 6x6 matrix as six words, rows 0..5;
//   m_axis_tdata holds the row index and the six Q32.32 entries, tlast
//   marks row 5 and tuser flags a zero-length element (all entries zero).
//   An accepted element runs through the arithmetic pipeline into the
//   output register, which gives its first row; the remaining five rows
//   follow one per cycle while the receiver is ready. The six rows share
//   one output port. The arithmetic pipeline takes a new word whenever it
//   is not held, so up to 75 elements may be in flight.
//   The next matrix loads into the output register in the cycle its
//   predecessor's last row is taken, so rows leave back to back.
//   Reset clears all valid bits; no result is pending afterwards.
//   When the receiver stalls, the current row holds, and once a finished
//   matrix waits in the pipeline's last stage, the whole pipeline and
//   s_axis_tready hold too; nothing is dropped or repeated.
`default_nettype none

module frame_element_stiffness_2d
  import fesk_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // youngs_modulus, second_moment, section_area, beam_length,
  // start_x, start_y, end_x, end_y (32 bits each)
  input  wire logic [InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // row_index (3), entry_col0..entry_col5 (64 each), zero padding (5)
  output logic [OutW-1:0]      m_axis_tdata,
  output logic                 m_axis_tlast,
  // zero_length
  output logic                 m_axis_tuser
);

  logic      core_valid;
  logic      can_load;
  fesk_mat_t core_mat;
  fesk_mat_t mat_q;
  logic      busy_q;
  logic [2:0] row_q;
  logic [NumCols-1:0][63:0] entry;

  function automatic logic [63:0] pick(input fesk_mat_t m, input sel_e s);
    logic [63:0] r;
    case (s)
      SEL_P:   r = m.pos[IdxP];
      SEL_Q:   r = m.pos[IdxQ];
      SEL_R:   r = m.pos[IdxR];
      SEL_CS:  r = m.pos[IdxCs];
      SEL_CC:  r = m.pos[IdxCc];
      SEL_D:   r = m.pos[IdxD];
      SEL_E:   r = m.pos[IdxE];
      SEL_NP:  r = m.neg[IdxP];
      SEL_NQ:  r = m.neg[IdxQ];
      SEL_NR:  r = m.neg[IdxR];
      SEL_NCS: r = m.neg[IdxCs];
      SEL_NCC: r = m.neg[IdxCc];
      SEL_ND:  r = m.neg[IdxD];
      SEL_NE:  r = m.neg[IdxE];
      default: r = '0;
    endcase
    return r;
  endfunction

  fesk_core u_core (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (fesk_in_t'(s_axis_tdata)),
    .out_valid_o (core_valid),
    .out_ready_i (can_load),
    .out_data_o  (core_mat)
  );

  // A new matrix loads when the register is empty or its last row leaves.
  assign can_load = !busy_q || (m_axis_tready && row_q == LastRow);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else if (core_valid && can_load) begin
      busy_q <= 1'b1;
      row_q  <= '0;
    end else if (busy_q && m_axis_tready) begin
      if (row_q == LastRow) begin
        busy_q <= 1'b0;
        row_q  <= '0;
      end else begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid && can_load) begin
      mat_q <= core_mat;
    end
  end

  // Row word: entries picked from the stored values by the layout table.
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      entry[c] = pick(mat_q, RowSel[row_q][c]);
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {5'b0, entry, row_q};
  assign m_axis_tlast  = row_q == LastRow;
  assign m_axis_tuser  = mat_q.zero;

`ifndef SYNTHESIS
  a_row_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> row_q <= LastRow)
    else $error("row index out of range");

  a_row_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && row_q == $past(row_q) + 3'd1))
    else $error("row sequence broken");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast && !core_valid) |=> !m_axis_tvalid)
    else $error("matrix repeated after its last row");

  a_zero_rows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[386:3] == '0)
    else $error("zero length element with nonzero entries");
`endif

endmodule

`default_nettype wire

// ===== src/fesk_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit. No dependencies.
`default_nettype none

module fesk_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o,
  output logic               ovf_o
);

  localparam int NP = NW + QW;

  logic [NP-1:0] npad;
  logic [NP-1:0] hi;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] nq_q  [QW+1];
  logic          ovf_q [QW+1];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] nq_d  [QW];

  // The part above the quotient bits seeds the remainder; if it already
  // reaches the divisor the quotient overflows.
  assign npad = NP'(num_i);
  assign hi   = npad >> QW;

  // One restoring step per stage: numerator bits shift out at the top of
  // nq while quotient bits shift in at the bottom.
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fit;
    assign trial    = {rem_q[s], nq_q[s][QW-1]};
    assign diff     = trial - {1'b0, den_q[s]};
    assign fit      = trial >= {1'b0, den_q[s]};
    assign rem_d[s] = fit ? diff[DW-1:0] : trial[DW-1:0];
    assign nq_d[s]  = {nq_q[s][QW-2:0], fit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= hi[DW-1:0];
      den_q[0] <= den_i;
      nq_q[0]  <= npad[QW-1:0];
      ovf_q[0] <= hi >= NP'(den_i);
      for (int s = 0; s < QW - 1; s++) begin
        rem_q[s+1] <= rem_d[s];
        den_q[s+1] <= den_q[s];
      end
      for (int s = 0; s < QW; s++) begin
        nq_q[s+1]  <= nq_d[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  assign quo_o = nq_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

`default_nettype wire

// ===== src/fesk_core.sv =====
// Arithmetic pipeline: stiffness terms, direction cosines and the seven
// distinct matrix values. Depends on fesk_pkg and fesk_div.
`default_nettype none

module fesk_core
  import fesk_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire fesk_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output fesk_mat_t      out_data_o
);

  typedef struct packed {
    logic vld;
    logic zero;
    logic xneg;
    logic yneg;
  } side_t;

  typedef struct packed {
    logic [63:0] p11;
    logic [63:0] p10;
    logic [63:0] p01;
    logic [63:0] p00;
  } pp_t;

  localparam int MP1 = 0;
  localparam int MP2 = 1;
  localparam int MR1 = 2;
  localparam int MR2 = 3;
  localparam int MQ  = 4;
  localparam int MCS = 5;
  localparam int MCC = 6;
  localparam int NumMul = 7;

  // 64x64 product as four 32x32 partial products.
  function automatic pp_t pp_mul(input logic [63:0] x, input logic [63:0] y);
    pp_t p;
    p.p00 = x[31:0]  * y[31:0];
    p.p01 = x[31:0]  * y[63:32];
    p.p10 = x[63:32] * y[31:0];
    p.p11 = x[63:32] * y[63:32];
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return {64'b0, p.p00} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
         + {p.p11, 64'b0};
  endfunction

  // Apply a sign, shift right toward minus infinity, saturate to signed 64.
  function automatic logic [63:0] shr_sat(input logic neg, input logic [127:0] mag,
                                          input int unsigned sh);
    logic signed [128:0] t;
    logic signed [128:0] s;
    logic [63:0]         r;
    t = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    s = t >>> sh;
    if (s[128:63] == '0 || s[128:63] == '1) begin
      r = s[63:0];
    end else if (s[128]) begin
      r = MinS64;
    end else begin
      r = MaxS64;
    end
    return r;
  endfunction

  // Saturate a quotient to 2^63-1.
  function automatic logic [63:0] sat63(input logic [63:0] q, input logic ovf);
    return (ovf || q[63]) ? MaxS64 : q;
  endfunction

  logic en;

  // Stage valids.
  logic v1_q, v2_q, v3_q, v4_q, vE_q, vF_q, vG_q, vH_q, vI_q, vJ_q;
  side_t side_q [QuoW+1];

  // Stage 1: input register.
  fesk_in_t in_q;

  // Stage 2: element products and coordinate differences.
  logic [63:0] ea2_q, ei2_q, l2_2_q;
  logic [31:0] len2_q;
  logic [32:0] xm2_q, ym2_q;
  logic        xn2_q, yn2_q, z2_q;
  logic [32:0] dx, dy;

  // Stage 3: cube partials and scaled numerators.
  logic [63:0] cl3_q, ch3_q, ea3_q, ei3_q, l2_3_q;
  logic [67:0] ei12_3_q;
  logic [66:0] ei6_3_q;
  logic [31:0] len3_q;
  logic [32:0] xm3_q, ym3_q;
  logic        xn3_q, yn3_q, z3_q;

  // Stage 4: divider operands.
  logic [95:0] cube4_q;
  logic [63:0] ea4_q, ei4_q, l2_4_q;
  logic [67:0] ei12_4_q;
  logic [66:0] ei6_4_q;
  logic [31:0] len4_q;
  logic [32:0] xm4_q, ym4_q;
  logic        xn4_q, yn4_q, z4_q;

  // Divider results.
  logic [QuoW-1:0] qx, qy, qa, qb, qc, qd;
  logic            ox, oy, oa, ob, oc, od;

  // Stage E: saturated stiffness terms and cosines.
  logic [63:0] kaE_q, kbE_q, kcE_q, kdE_q, keE_q;
  logic [30:0] cmE_q, smE_q;
  logic        xnE_q, ynE_q, zE_q;

  // Stage F: squares and the axial-bending difference.
  logic [63:0] kaF_q, kbF_q, kcF_q, kdF_q, keF_q;
  logic [61:0] c2F_q, s2F_q, csF_q;
  logic [62:0] dmF_q;
  logic [30:0] cmF_q, smF_q;
  logic        qnF_q, xnF_q, ynF_q, zF_q;
  logic [63:0] dif;

  // Stage G: partial products.
  pp_t         ppG_q [NumMul];
  logic [63:0] kdG_q, keG_q;
  logic        qnG_q, xnG_q, ynG_q, zG_q;

  // Stage H: full products.
  logic [127:0] prH_q [NumMul];
  logic [63:0]  kdH_q, keH_q;
  logic         qnH_q, xnH_q, ynH_q, zH_q;

  // Stage I and J: values, then their negations.
  logic [63:0] valI_q [NumVals];
  logic        zI_q;
  fesk_mat_t   matJ_q;

  // The whole pipeline holds while the finished matrix is not taken.
  assign en         = !vJ_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    dx = {in_q.end_x[31], in_q.end_x} - {in_q.start_x[31], in_q.start_x};
    dy = {in_q.end_y[31], in_q.end_y} - {in_q.start_y[31], in_q.start_y};
    dif = kaE_q - kbE_q;
  end

  // Dividers: cosines, axial term and the three bending quotients.
  fesk_div #(.NW(63), .DW(32), .QW(QuoW)) u_div_x (
    .clk_i, .en_i(en), .num_i({xm4_q, 30'b0}), .den_i(len4_q), .quo_o(qx), .ovf_o(ox)
  );
  fesk_div #(.NW(63), .DW(32), .QW(QuoW)) u_div_y (
    .clk_i, .en_i(en), .num_i({ym4_q, 30'b0}), .den_i(len4_q), .quo_o(qy), .ovf_o(oy)
  );
  fesk_div #(.NW(80), .DW(32), .QW(QuoW)) u_div_a (
    .clk_i, .en_i(en), .num_i({ea4_q, 16'b0}), .den_i(len4_q), .quo_o(qa), .ovf_o(oa)
  );
  fesk_div #(.NW(116), .DW(96), .QW(QuoW)) u_div_b (
    .clk_i, .en_i(en), .num_i({ei12_4_q, 48'b0}), .den_i(cube4_q), .quo_o(qb), .ovf_o(ob)
  );
  fesk_div #(.NW(99), .DW(64), .QW(QuoW)) u_div_c (
    .clk_i, .en_i(en), .num_i({ei6_4_q, 32'b0}), .den_i(l2_4_q), .quo_o(qc), .ovf_o(oc)
  );
  fesk_div #(.NW(82), .DW(32), .QW(QuoW)) u_div_d (
    .clk_i, .en_i(en), .num_i({ei4_q, 18'b0}), .den_i(len4_q), .quo_o(qd), .ovf_o(od)
  );

  // Valid bits and the sign flags that ride along the dividers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vE_q <= 1'b0;
      vF_q <= 1'b0;
      vG_q <= 1'b0;
      vH_q <= 1'b0;
      vI_q <= 1'b0;
      vJ_q <= 1'b0;
      for (int s = 0; s <= QuoW; s++) begin
        side_q[s] <= '0;
      end
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      side_q[0] <= '{vld: v4_q, zero: z4_q, xneg: xn4_q, yneg: yn4_q};
      for (int s = 0; s < QuoW; s++) begin
        side_q[s+1] <= side_q[s];
      end
      vE_q <= side_q[QuoW].vld;
      vF_q <= vE_q;
      vG_q <= vF_q;
      vH_q <= vG_q;
      vI_q <= vH_q;
      vJ_q <= vI_q;
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;

      // Stage 2: 32x32 products and end differences.
      ea2_q  <= in_q.youngs_modulus * in_q.section_area;
      ei2_q  <= in_q.youngs_modulus * in_q.second_moment;
      l2_2_q <= in_q.beam_length * in_q.beam_length;
      len2_q <= in_q.beam_length;
      z2_q   <= in_q.beam_length == '0;
      xn2_q  <= dx[32];
      yn2_q  <= dy[32];
      xm2_q  <= dx[32] ? -dx : dx;
      ym2_q  <= dy[32] ? -dy : dy;

      // Stage 3: L^3 partials, 12*EI and 6*EI.
      cl3_q    <= l2_2_q[31:0] * len2_q;
      ch3_q    <= l2_2_q[63:32] * len2_q;
      ei12_3_q <= (68'(ei2_q) << 3) + (68'(ei2_q) << 2);
      ei6_3_q  <= (67'(ei2_q) << 2) + (67'(ei2_q) << 1);
      ea3_q    <= ea2_q;
      ei3_q    <= ei2_q;
      l2_3_q   <= l2_2_q;
      len3_q   <= len2_q;
      xm3_q    <= xm2_q;
      ym3_q    <= ym2_q;
      xn3_q    <= xn2_q;
      yn3_q    <= yn2_q;
      z3_q     <= z2_q;

      // Stage 4: L^3.
      cube4_q  <= 96'(cl3_q) + {ch3_q, 32'b0};
      ei12_4_q <= ei12_3_q;
      ei6_4_q  <= ei6_3_q;
      ea4_q    <= ea3_q;
      ei4_q    <= ei3_q;
      l2_4_q   <= l2_3_q;
      len4_q   <= len3_q;
      xm4_q    <= xm3_q;
      ym4_q    <= ym3_q;
      xn4_q    <= xn3_q;
      yn4_q    <= yn3_q;
      z4_q     <= z3_q;

      // Stage E: saturate terms; 2EI/L is half of 4EI/L.
      kaE_q <= sat63(qa, oa);
      kbE_q <= sat63(qb, ob);
      kcE_q <= sat63(qc, oc);
      kdE_q <= sat63(qd, od);
      keE_q <= od ? MaxS64 : {1'b0, qd[63:1]};
      cmE_q <= (ox || qx[63:31] != '0) ? '1 : qx[30:0];
      smE_q <= (oy || qy[63:31] != '0) ? '1 : qy[30:0];
      xnE_q <= side_q[QuoW].xneg;
      ynE_q <= side_q[QuoW].yneg;
      zE_q  <= side_q[QuoW].zero;

      // Stage F: cosine products and |a - b|.
      c2F_q <= cmE_q * cmE_q;
      s2F_q <= smE_q * smE_q;
      csF_q <= cmE_q * smE_q;
      dmF_q <= dif[63] ? 63'(-dif) : dif[62:0];
      qnF_q <= dif[63] ^ xnE_q ^ ynE_q;
      kaF_q <= kaE_q;
      kbF_q <= kbE_q;
      kcF_q <= kcE_q;
      kdF_q <= kdE_q;
      keF_q <= keE_q;
      cmF_q <= cmE_q;
      smF_q <= smE_q;
      xnF_q <= xnE_q;
      ynF_q <= ynE_q;
      zF_q  <= zE_q;

      // Stage G: partial products of the seven wide multiplies.
      ppG_q[MP1] <= pp_mul(kaF_q, {2'b0, c2F_q});
      ppG_q[MP2] <= pp_mul(kbF_q, {2'b0, s2F_q});
      ppG_q[MR1] <= pp_mul(kaF_q, {2'b0, s2F_q});
      ppG_q[MR2] <= pp_mul(kbF_q, {2'b0, c2F_q});
      ppG_q[MQ]  <= pp_mul({1'b0, dmF_q}, {2'b0, csF_q});
      ppG_q[MCS] <= pp_mul(kcF_q, {33'b0, smF_q});
      ppG_q[MCC] <= pp_mul(kcF_q, {33'b0, cmF_q});
      kdG_q <= kdF_q;
      keG_q <= keF_q;
      qnG_q <= qnF_q;
      xnG_q <= xnF_q;
      ynG_q <= ynF_q;
      zG_q  <= zF_q;

      // Stage H: full products.
      for (int m = 0; m < NumMul; m++) begin
        prH_q[m] <= pp_sum(ppG_q[m]);
      end
      kdH_q <= kdG_q;
      keH_q <= keG_q;
      qnH_q <= qnG_q;
      xnH_q <= xnG_q;
      ynH_q <= ynG_q;
      zH_q  <= zG_q;

      // Stage I: sums, flooring shifts and saturation; zero length clears all.
      if (zH_q) begin
        for (int k = 0; k < NumVals; k++) begin
          valI_q[k] <= '0;
        end
      end else begin
        valI_q[IdxP]  <= shr_sat(1'b0, prH_q[MP1] + prH_q[MP2], 60);
        valI_q[IdxQ]  <= shr_sat(qnH_q, prH_q[MQ], 60);
        valI_q[IdxR]  <= shr_sat(1'b0, prH_q[MR1] + prH_q[MR2], 60);
        valI_q[IdxCs] <= shr_sat(ynH_q, prH_q[MCS], 30);
        valI_q[IdxCc] <= shr_sat(xnH_q, prH_q[MCC], 30);
        valI_q[IdxD]  <= kdH_q;
        valI_q[IdxE]  <= keH_q;
      end
      zI_q <= zH_q;

      // Stage J: saturating negations.
      for (int k = 0; k < NumVals; k++) begin
        matJ_q.pos[k] <= valI_q[k];
        matJ_q.neg[k] <= (valI_q[k] == MinS64) ? MaxS64 : -valI_q[k];
      end
      matJ_q.zero <= zI_q;
    end
  end

  assign out_valid_o = vJ_q;
  assign out_data_o  = matJ_q;

endmodule

`default_nettype wire

// ===== dv/frame_element_stiffness_2d_tb.sv =====
// Self-checking testbench for frame_element_stiffness_2d: random and directed
// beam elements, a bit-exact matrix predictor and row-by-row checks.
// Depends on fesk_pkg and the frame_element_stiffness_2d RTL.
`default_nettype none

module frame_element_stiffness_2d_tb
  import fesk_pkg::*;
();

  // One expected matrix row.
  typedef struct {
    logic [2:0]  row;
    logic [63:0] ent [NumCols];
    logic        last;
    logic        zero;
  } mat_row_t;

  // Matrix predictor and the store of rows still to come.
  class stiffness_board;
    mat_row_t pending_rows[$];
    int       fail_cnt;
    int       rows_seen;
    int       zero_seen;
    int       sat_seen;

    function automatic logic [63:0] neg_sat(logic [63:0] v);
      return (v == MinS64) ? MaxS64 : (~v + 64'd1);
    endfunction

    // Q1.30 direction cosine of one coordinate difference.
    function automatic longint dir_cos(logic signed [32:0] dlt, logic [31:0] len);
      logic [63:0] mag;
      logic [63:0] quo;
      mag = dlt[32] ? 64'(-dlt) : 64'(dlt);
      quo = (mag << 30) / {32'd0, len};
      if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
      return dlt[32] ? -longint'(quo) : longint'(quo);
    endfunction

    // floor(prod * k * 2^s / len^ndiv), saturated to the positive Q32.32 range.
    function automatic logic [63:0] beam_term(logic [63:0] prod, int unsigned k,
                                              int unsigned s, int unsigned ndiv,
                                              logic [31:0] len);
      logic [127:0] w;
      w = ({64'd0, prod} * 128'(k)) << s;
      repeat (ndiv) w = w / {96'd0, len};
      if (w > 128'h7FFF_FFFF_FFFF_FFFF) begin
        sat_seen++;
        return MaxS64;
      end
      return w[63:0];
    endfunction

    // Exact signed product of a stiffness term and a trig product.
    function automatic logic signed [127:0] scaled(logic [63:0] stf, longint trig);
      logic [127:0] r;
      r = {64'd0, stf} * {64'd0, (trig < 0) ? 64'(-trig) : 64'(trig)};
      return (trig < 0) ? $signed(-r) : $signed(r);
    endfunction

    // Arithmetic shift right, saturated to signed 64 bits.
    function automatic logic [63:0] shr_sat(logic signed [127:0] x, int unsigned n);
      logic signed [127:0] y;
      y = x >>> n;
      if (&y[127:63] || ~|y[127:63]) return y[63:0];
      sat_seen++;
      return x[127] ? MinS64 : MaxS64;
    endfunction

    // Work out the six rows of one accepted element.
    function automatic void note_element(fesk_in_t el);
      logic [63:0] vals [NumVals];
      mat_row_t    mr;
      longint      cc, ss, c2, s2, cs;
      logic [63:0] ei, ka, kb, kc;
      sel_e        sel;
      foreach (vals[i]) vals[i] = '0;
      if (el.beam_length != 0) begin
        cc = dir_cos(33'(el.end_x) - 33'(el.start_x), el.beam_length);
        ss = dir_cos(33'(el.end_y) - 33'(el.start_y), el.beam_length);
        c2 = cc * cc;
        s2 = ss * ss;
        cs = cc * ss;
        ei = 64'(el.youngs_modulus) * 64'(el.second_moment);
        ka = beam_term(64'(el.youngs_modulus) * 64'(el.section_area), 1, 16, 1,
                       el.beam_length);
        kb = beam_term(ei, 12, 48, 3, el.beam_length);
        kc = beam_term(ei, 6, 32, 2, el.beam_length);
        vals[IdxD]  = beam_term(ei, 4, 16, 1, el.beam_length);
        vals[IdxE]  = beam_term(ei, 2, 16, 1, el.beam_length);
        vals[IdxP]  = shr_sat(scaled(ka, c2) + scaled(kb, s2), 60);
        vals[IdxQ]  = shr_sat(scaled(ka, cs) + scaled(kb, -cs), 60);
        vals[IdxR]  = shr_sat(scaled(ka, s2) + scaled(kb, c2), 60);
        vals[IdxCs] = shr_sat(scaled(kc, ss), 30);
        vals[IdxCc] = shr_sat(scaled(kc, cc), 30);
      end
      for (int r = 0; r < NumRows; r++) begin
        mr.row  = 3'(r);
        mr.last = (3'(r) == LastRow);
        mr.zero = (el.beam_length == 0);
        for (int j = 0; j < NumCols; j++) begin
          sel = RowSel[r][j];
          mr.ent[j] = (sel >= SEL_NP) ? neg_sat(vals[int'(sel) - int'(SEL_NP)])
                                      : vals[int'(sel)];
        end
        pending_rows = {pending_rows, mr};
      end
    endfunction

    // Compare one accepted row with the oldest expectation.
    function automatic void check_row(logic [OutW-1:0] dat, logic lst, logic usr);
      mat_row_t exp_row;
      rows_seen++;
      if (pending_rows.size() == 0) begin
        $display("%0t: row with no expectation: index %0d", $time, dat[2:0]);
        fail_cnt++;
        return;
      end
      exp_row = pending_rows.pop_front();
      if (usr) zero_seen++;
      if (dat[2:0] !== exp_row.row) begin
        $display("%0t: row_index expected %0d actual %0d", $time, exp_row.row, dat[2:0]);
        fail_cnt++;
      end
      for (int j = 0; j < NumCols; j++) begin
        if (dat[3 + 64*j +: 64] !== exp_row.ent[j]) begin
          $display("%0t: row %0d col %0d expected %h actual %h", $time, exp_row.row, j,
                   exp_row.ent[j], dat[3 + 64*j +: 64]);
          fail_cnt++;
        end
      end
      if (lst !== exp_row.last) begin
        $display("%0t: last_row expected %b actual %b", $time, exp_row.last, lst);
        fail_cnt++;
      end
      if (usr !== exp_row.zero) begin
        $display("%0t: zero_length expected %b actual %b", $time, exp_row.zero, usr);
        fail_cnt++;
      end
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            m_axis_tlast;
  logic            m_axis_tuser;

  stiffness_board board = new();
  int  elements_sent;
  bit  steady;          // no idling on either side while set
  int  stall_left;

  frame_element_stiffness_2d u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
  endfunction

  // Receiver stalls.
  always @(negedge clk_i) begin
    if (!rst_ni || steady) begin
      m_axis_tready <= rst_ni;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Row check on every accepted output word.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_row(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Send one element word, with an optional idle gap in front.
  task automatic send_element(fesk_in_t el);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= el;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_element(el);
    elements_sent++;
  endtask

  // Random 32-bit value biased toward extremes and small magnitudes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      2:       return 32'(1) << $urandom_range(0, 31);
      3, 4:    return $urandom;
      default: return $urandom_range(1, 32'h00FF_FFFF);
    endcase
  endfunction

  task automatic send_beam(logic [31:0] e, logic [31:0] i, logic [31:0] a,
                           logic [31:0] l, logic [31:0] x0, logic [31:0] y0,
                           logic [31:0] x1, logic [31:0] y1);
    fesk_in_t el;
    el = '{end_y: y1, end_x: x1, start_y: y0, start_x: x0, beam_length: l,
           section_area: a, second_moment: i, youngs_modulus: e};
    send_element(el);
  endtask

  initial begin
    logic [31:0] len, x0, y0, dx, dy;
    steady = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed elements: zero length, extremes, saturation, axis-aligned beams.
    send_beam(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0, 0, 0, 32'h0001_0000, 0);
    send_beam('1, '1, '1, 32'd0, '1, '1, '1, '1);
    send_beam(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              0, 0, 32'h0001_0000, 0);
    send_beam(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              0, 0, 0, 32'h0001_0000);
    send_beam(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000, 32'h0001_0000, 0, 0);
    send_beam('1, '1, '1, 32'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    send_beam('1, '1, '1, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000);
    send_beam('1, '1, '1, '1, 0, 0, 0, 0);
    send_beam(0, 0, 0, '1, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
    send_beam(32'h0020_0000, 32'h0000_0100, 32'h0004_0000, 32'h0005_0000,
              0, 0, 32'h0003_0000, 32'h0004_0000);
    send_beam(32'h0020_0000, 32'h0000_0100, 32'h0004_0000, 32'h0005_0000,
              32'h0003_0000, 32'h0004_0000, 0, 0);
    send_beam(32'h0020_0000, 32'h0000_0100, 32'h0004_0000, 32'h0001_0000,
              0, 0, 32'h0003_0000, 32'hFFFC_0000);
    send_beam(32'd1, 32'd1, 32'd1, '1, 0, 0, 32'd1, 32'd1);
    send_beam('1, 32'd0, '1, 32'h0001_0000, 0, 0, 32'h0000_B505, 32'h0000_B505);
    send_beam(32'd0, '1, 32'd0, 32'h0000_0100, 0, 0, 32'hFFFF_FF00, 32'h0000_0100);

    // Random elements; a middle stretch runs with no idling at all.
    for (int n = 0; n < 150; n++) begin
      steady = (n >= 60 && n < 80);
      case ($urandom_range(0, 3))
        0: send_beam(pick_word(), pick_word(), pick_word(), pick_word(),
                     $urandom, $urandom, $urandom, $urandom);
        default: begin
          // Plausible beam: the length roughly matches the end distance.
          x0  = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
          y0  = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
          dx  = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
          dy  = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
          len = (dx[31] ? -dx : dx) + (dy[31] ? -dy : dy) + $urandom_range(0, 3);
          if ($urandom_range(0, 19) == 0) len = 0;
          send_beam($urandom_range(1, 32'h0FFF_FFFF), $urandom_range(1, 32'h000F_FFFF),
                    $urandom_range(1, 32'h00FF_FFFF), len, x0, y0, x0 + dx, y0 + dy);
        end
      endcase
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    steady = 1'b1;

    while (board.pending_rows.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d beam elements and checked %0d matrix rows (%0d zero-length rows).",
             elements_sent, board.rows_seen, board.zero_seen);
    $display("Saturated terms predicted: %0d.", board.sat_seen);
    if (board.fail_cnt == 0 && board.pending_rows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
